### hdl/acf_pkg.sv
// acf_pkg: shared types, register indexes and reset values of the altitude fusion block
// standalone, no dependencies; used by every file of the block

package acf_pkg;

   // gains, dt and weights all carry this many fraction bits
   localparam int GAIN_FRAC = 16;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUND_LEVEL     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BARO_SMOOTHING   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALTITUDE_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_GAIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_DAMPING = 3'd4;

   localparam logic signed [31:0] RST_GROUND_LEVEL     = 32'sd0;
   localparam logic [16:0]        RST_BARO_SMOOTHING   = 17'd9830;
   localparam logic [17:0]        RST_ALTITUDE_GAIN    = 18'd9830;
   localparam logic [17:0]        RST_VELOCITY_GAIN    = 18'd78643;
   localparam logic [16:0]        RST_VELOCITY_DAMPING = 17'd58982;

   // exactly one in Q1.16
   localparam logic [16:0] GAIN_ONE = 17'd65536;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 19;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic signed [31:0] accel_up;
      logic [15:0]        dt_step;
      logic signed [31:0] baro_height;
      logic               baro_valid;
   } req_type;

   typedef struct packed {
      logic signed [31:0] fused_altitude;
      logic signed [31:0] fused_velocity;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] ground_level;
      logic [16:0]        baro_smoothing;
      logic [17:0]        altitude_gain;
      logic [17:0]        velocity_gain;
      logic [16:0]        velocity_damping;
   } cfg_type;

endpackage

### hdl/altitude_complementary_fusion.sv
// altitude_complementary_fusion: baro / accelerometer complementary altitude filter, top level
// depends on acf_pkg, acf_csr and acf_mac
//
// req channel: one beat per IMU step (accel_up, dt_step, baro_height, baro_valid),
// taken when req_valid is high and req_stall low. rsp channel: one beat per step with the
// fused altitude and damped velocity, taken when rsp_valid is high and rsp_stall low.
// csr channel: register writes (index 0..4), always ready, taken when csr_valid is high;
// write only while no step is in flight.
// Each step runs through the single multiply-accumulate unit, operation by operation
// (multiply, then round/add/saturate): 3 operations without a new baro sample and 7 with
// one. req_stall is high from the req beat until the result is in the output register,
// so a new step is taken only once the previous one is through. If the output register is
// still full with rsp_stall high when a step completes, the block waits with req_stall
// high until the previous beat is taken. A stalled rsp beat holds.
// Reset (synchronous, active high) clears velocity, altitude and filtered baro state,
// loads the register defaults and empties the output register.

module altitude_complementary_fusion (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  acf_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output acf_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [acf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   localparam logic [2:0] OP_VEL  = 3'd0;
   localparam logic [2:0] OP_ALT  = 3'd1;
   localparam logic [2:0] OP_REL  = 3'd2;
   localparam logic [2:0] OP_FB   = 3'd3;
   localparam logic [2:0] OP_ALTC = 3'd4;
   localparam logic [2:0] OP_VELC = 3'd5;
   localparam logic [2:0] OP_DAMP = 3'd6;

   localparam logic signed [acf_pkg::MUL_B_W-1:0] NEG_ONE_Q16 = -19'sd65536;

   acf_pkg::cfg_type cfg;
   acf_pkg::req_type req_ff, req_in;
   acf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] vel_ff, vel_in;
   logic signed [31:0] alt_ff, alt_in;
   logic signed [31:0] fb_ff, fb_in;
   logic signed [32:0] tmp_ff, tmp_in;

   logic [16:0]                          smooth_w;
   logic [16:0]                          damp_w;
   logic signed [32:0]                   err_now;
   logic signed [32:0]                   diff_now;
   logic signed [acf_pkg::MUL_A_W-1:0]   mul_a;
   logic signed [acf_pkg::MUL_B_W-1:0]   mul_b;
   logic signed [31:0]                   add_base;
   logic signed [31:0]                   sum_sat;
   logic                                 req_beat;
   logic                                 out_free;

   acf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   acf_mac u_mac (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .add_base (add_base),
      .sum_sat  (sum_sat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // weights above one act as exactly one
   assign smooth_w = (cfg.baro_smoothing > acf_pkg::GAIN_ONE) ? acf_pkg::GAIN_ONE
                                                             : cfg.baro_smoothing;
   assign damp_w   = (cfg.velocity_damping > acf_pkg::GAIN_ONE) ? acf_pkg::GAIN_ONE
                                                               : cfg.velocity_damping;

   assign err_now  = $signed({fb_ff[31], fb_ff}) - $signed({alt_ff[31], alt_ff});
   assign diff_now = tmp_ff - $signed({fb_ff[31], fb_ff});

   // operand and base select
   always_comb begin
      case (op_ff)
         OP_VEL: begin
            mul_a    = $signed({{2{req_ff.accel_up[31]}}, req_ff.accel_up});
            mul_b    = $signed({3'd0, req_ff.dt_step});
            add_base = vel_ff;
         end
         OP_ALT: begin
            mul_a    = $signed({{2{vel_ff[31]}}, vel_ff});
            mul_b    = $signed({3'd0, req_ff.dt_step});
            add_base = alt_ff;
         end
         OP_REL: begin
            mul_a    = $signed({{2{cfg.ground_level[31]}}, cfg.ground_level});
            mul_b    = NEG_ONE_Q16;
            add_base = req_ff.baro_height;
         end
         OP_FB: begin
            mul_a    = $signed({diff_now[32], diff_now});
            mul_b    = $signed({2'd0, smooth_w});
            add_base = fb_ff;
         end
         OP_ALTC: begin
            mul_a    = $signed({err_now[32], err_now});
            mul_b    = $signed({1'b0, cfg.altitude_gain});
            add_base = alt_ff;
         end
         OP_VELC: begin
            mul_a    = $signed({tmp_ff[32], tmp_ff});
            mul_b    = $signed({1'b0, cfg.velocity_gain});
            add_base = vel_ff;
         end
         OP_DAMP: begin
            mul_a    = $signed({{2{vel_ff[31]}}, vel_ff});
            mul_b    = $signed({2'd0, damp_w});
            add_base = 32'sd0;
         end
         default: begin
            mul_a    = '0;
            mul_b    = '0;
            add_base = 32'sd0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      vel_in       = vel_ff;
      alt_in       = alt_ff;
      fb_in        = fb_ff;
      tmp_in       = tmp_ff;
      req_in       = req_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               req_in   = req_data;
               op_in    = OP_VEL;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // error against the predicted altitude, kept for both corrections
            if (op_ff == OP_ALTC) begin
               tmp_in = err_now;
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_MUL;
            case (op_ff)
               OP_VEL: begin
                  vel_in = sum_sat;
                  op_in  = OP_ALT;
               end
               OP_ALT: begin
                  alt_in = sum_sat;
                  op_in  = req_ff.baro_valid ? OP_REL : OP_DAMP;
               end
               OP_REL: begin
                  tmp_in = $signed({sum_sat[31], sum_sat});
                  op_in  = OP_FB;
               end
               OP_FB: begin
                  fb_in = sum_sat;
                  op_in = OP_ALTC;
               end
               OP_ALTC: begin
                  alt_in = sum_sat;
                  op_in  = OP_VELC;
               end
               OP_VELC: begin
                  vel_in = sum_sat;
                  op_in  = OP_DAMP;
               end
               OP_DAMP: begin
                  vel_in = sum_sat;
                  if (out_free) begin
                     rsp_data_in.fused_altitude = alt_ff;
                     rsp_data_in.fused_velocity = sum_sat;
                     rsp_valid_in               = 1'b1;
                     state_in                   = ST_IDLE;
                  end else begin
                     state_in = ST_HOLD;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_data_in.fused_altitude = alt_ff;
               rsp_data_in.fused_velocity = vel_ff;
               rsp_valid_in               = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_VEL;
         rsp_valid_ff <= 1'b0;
         vel_ff       <= 32'sd0;
         alt_ff       <= 32'sd0;
         fb_ff        <= 32'sd0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         vel_ff       <= vel_in;
         alt_ff       <= alt_in;
         fb_ff        <= fb_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      tmp_ff      <= tmp_in;
      rsp_data_ff <= rsp_data_in;
   end

   // an accepted beat always starts the multiply of the first operation
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_MUL && op_ff == OP_VEL))
      else $error("step did not start on the velocity integration");

   // waiting for the receiver only happens with a full output register
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_valid_ff)
      else $error("hold state with empty output register");

   // the damping step ends the item with a result or a wait
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && op_ff == OP_DAMP)
      |=> ((state_ff == ST_IDLE && rsp_valid_ff) || state_ff == ST_HOLD))
      else $error("damping step did not deliver a result");

   // the correction path only runs for a fresh baro sample
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && op_ff == OP_ALT && !req_ff.baro_valid) |=> op_ff == OP_DAMP)
      else $error("correction ran without a fresh baro sample");

endmodule

### hdl/acf_csr.sv
// acf_csr: configuration registers of the altitude fusion block
// depends on acf_pkg for register indexes, reset values and cfg_type

module acf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [acf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_data,
   output acf_pkg::cfg_type                cfg
);

   acf_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            acf_pkg::CSR_GROUND_LEVEL:     cfg_in.ground_level     = $signed(csr_data);
            acf_pkg::CSR_BARO_SMOOTHING:   cfg_in.baro_smoothing   = csr_data[16:0];
            acf_pkg::CSR_ALTITUDE_GAIN:    cfg_in.altitude_gain    = csr_data[17:0];
            acf_pkg::CSR_VELOCITY_GAIN:    cfg_in.velocity_gain    = csr_data[17:0];
            acf_pkg::CSR_VELOCITY_DAMPING: cfg_in.velocity_damping = csr_data[16:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ground_level     <= acf_pkg::RST_GROUND_LEVEL;
         cfg_ff.baro_smoothing   <= acf_pkg::RST_BARO_SMOOTHING;
         cfg_ff.altitude_gain    <= acf_pkg::RST_ALTITUDE_GAIN;
         cfg_ff.velocity_gain    <= acf_pkg::RST_VELOCITY_GAIN;
         cfg_ff.velocity_damping <= acf_pkg::RST_VELOCITY_DAMPING;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/acf_mac.sv
// acf_mac: shared multiply, round, accumulate and saturate unit
// registered product, then round to nearest (ties up), add base, clamp to 32 bits; uses acf_pkg

module acf_mac (
   input  logic                                clock,
   input  logic signed [acf_pkg::MUL_A_W-1:0]  mul_a,
   input  logic signed [acf_pkg::MUL_B_W-1:0]  mul_b,
   input  logic signed [31:0]                  add_base,
   output logic signed [31:0]                  sum_sat
);

   localparam int SHIFT_W = acf_pkg::PROD_W - acf_pkg::GAIN_FRAC;
   localparam int SUM_W   = SHIFT_W + 1;
   localparam logic signed [acf_pkg::PROD_W-1:0] ROUND_HALF =
      acf_pkg::PROD_W'(1) <<< (acf_pkg::GAIN_FRAC - 1);

   logic signed [acf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [acf_pkg::PROD_W-1:0] rounded;
   logic signed [SHIFT_W-1:0]         shifted;
   logic signed [SUM_W-1:0]           sum;
   logic                              in_range;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      rounded  = prod_ff + ROUND_HALF;
      shifted  = $signed(rounded[acf_pkg::PROD_W-1:acf_pkg::GAIN_FRAC]);
      sum      = $signed({{(SUM_W-32){add_base[31]}}, add_base})
               + $signed({shifted[SHIFT_W-1], shifted});
      in_range = (&sum[SUM_W-1:31]) || !(|sum[SUM_W-1:31]);
      if (in_range) begin
         sum_sat = $signed(sum[31:0]);
      end else if (sum[SUM_W-1]) begin
         sum_sat = $signed({1'b1, 31'd0});
      end else begin
         sum_sat = $signed({1'b0, {31{1'b1}}});
      end
   end

endmodule
